>>> rtl/pca_pkg.sv
`timescale 1ns / 1ps
package pca_pkg;

  localparam int unsigned TABLE_DEPTH   = 128;
  localparam int unsigned RUN_SET_DEPTH = 32;

  localparam int unsigned TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RIDX_W = (RUN_SET_DEPTH > 1) ? $clog2(RUN_SET_DEPTH) : 1;
  localparam int unsigned RCNT_W = $clog2(RUN_SET_DEPTH + 1);

  // entries_used reports the low byte of the fill count
  localparam int unsigned USED_OUT_W = 8;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_OVERHEAD = REG_IDX_W'(0);

  typedef enum logic [2:0] {
    ST_RUN_START  = 3'd0,
    ST_ACCUM      = 3'd1,
    ST_NEW        = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_SET_FULL   = 3'd4,
    ST_READ_OK    = 3'd5,
    ST_READ_BAD   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FIN_START  = 2'd0,
    FIN_TFULL  = 2'd1,
    FIN_UPDATE = 2'd2,
    FIN_READ   = 2'd3
  } fin_kind_e;

  typedef enum logic [1:0] {
    SEL_HIT = 2'd0,
    SEL_NEW = 2'd1,
    SEL_REQ = 2'd2
  } ent_sel_e;

  typedef struct packed {
    logic        command;
    logic        first_in_run;
    logic [15:0] category;
    logic [15:0] timestamp;
    logic [6:0]  entry_index;
  } pca_in_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [15:0]           entry_category;
    logic [31:0]           entry_cycles;
    logic [15:0]           entry_episodes;
    logic [USED_OUT_W-1:0] entries_used;
  } pca_out_t;

  typedef struct packed {
    logic      load_in;
    logic      t_start;
    logic      t_scan;
    logic      ent_latch;
    ent_sel_e  ent_sel;
    logic      rd_entry;
    logic      r_scan;
    logic      finish;
    fin_kind_e fin_kind;
  } pca_cmd_t;

  typedef struct packed {
    logic cmd_read;
    logic cmd_first;
    logic have_prev;
    logic req_ok;
    logic t_hit;
    logic t_end;
    logic t_full;
    logic r_hit;
    logic r_end;
    logic out_free;
  } pca_stat_t;

endpackage

>>> rtl/profile_category_aggregator_core.sv
`timescale 1ns / 1ps
// channel   handshake                    payload
// input     in_valid_i / in_ready_o      in_data_i  (pca_in_t)
// output    out_valid_o / out_ready_i    out_data_o (pca_out_t)
// config    psel penable pwrite pready   paddr pwdata prdata (overhead at 0x0)
//
// one item at a time; the work on a record is set by the linear key search through the
// table memory and then the run set memory, one key per cycle
// run start and a table read do no key search
// a new item is taken while the previous result still sits in the output register
// reset is asynchronous, active low; table and run-set memories need no clearing
// a stalled output only holds the finishing item until the result register frees up
module profile_category_aggregator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  pca_pkg::pca_in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output pca_pkg::pca_out_t                     out_data_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pca_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [pca_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [pca_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import pca_pkg::*;

  logic [15:0]          overhead_q;
  logic [REG_IDX_W-1:0] reg_idx;
  pca_cmd_t             cmd;
  pca_stat_t            stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign prdata  = (reg_idx == REG_OVERHEAD) ? APB_DATA_W'(overhead_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overhead_q <= '0;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_OVERHEAD)) begin
      overhead_q <= pwdata[15:0];
    end
  end

  pca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .overhead_i  (overhead_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/pca_ctrl.sv
`timescale 1ns / 1ps
module pca_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pca_pkg::pca_stat_t  stat_i,
  output pca_pkg::pca_cmd_t   cmd_o
);
  import pca_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_TSCAN  = 6'b000100,
    S_RDENT  = 6'b001000,
    S_RSCAN  = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  fin_kind_e kind_q, kind_d;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.t_start = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.cmd_read) begin
          kind_d = FIN_READ;
          if (stat_i.req_ok) begin
            cmd_o.ent_latch = 1'b1;
            cmd_o.ent_sel   = SEL_REQ;
            state_d         = S_RDENT;
          end else begin
            state_d = S_FIN;
          end
        end else if (stat_i.cmd_first || !stat_i.have_prev) begin
          kind_d  = FIN_START;
          state_d = S_FIN;
        end else begin
          state_d = S_TSCAN;
        end
      end
      S_TSCAN: begin
        cmd_o.t_scan = 1'b1;
        if (stat_i.t_hit) begin
          cmd_o.ent_latch = 1'b1;
          cmd_o.ent_sel   = SEL_HIT;
          kind_d          = FIN_UPDATE;
          state_d         = S_RDENT;
        end else if (stat_i.t_end) begin
          if (stat_i.t_full) begin
            kind_d  = FIN_TFULL;
            state_d = S_FIN;
          end else begin
            // new entry needs no read, go straight to the run set
            cmd_o.ent_latch = 1'b1;
            cmd_o.ent_sel   = SEL_NEW;
            kind_d          = FIN_UPDATE;
            state_d         = S_RSCAN;
          end
        end
      end
      S_RDENT: begin
        cmd_o.rd_entry = 1'b1;
        state_d        = (kind_q == FIN_UPDATE) ? S_RSCAN : S_FIN;
      end
      S_RSCAN: begin
        cmd_o.r_scan = 1'b1;
        if (stat_i.r_hit || stat_i.r_end) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_kind = kind_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= FIN_START;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

>>> rtl/pca_dp.sv
`timescale 1ns / 1ps
module pca_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pca_pkg::pca_cmd_t  cmd_i,
  output pca_pkg::pca_stat_t stat_o,
  input  pca_pkg::pca_in_t   in_data_i,
  input  logic [15:0]        overhead_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pca_pkg::pca_out_t  out_data_o
);
  import pca_pkg::*;

  localparam int unsigned IDXCMP_W = TCNT_W + 7;
  localparam int unsigned USEDX_W  = TCNT_W + USED_OUT_W;

  logic [15:0] key_mem [TABLE_DEPTH];
  logic [31:0] cyc_mem [TABLE_DEPTH];
  logic [15:0] epi_mem [TABLE_DEPTH];
  logic [15:0] rs_mem  [RUN_SET_DEPTH];

  pca_in_t           in_q;
  logic [TCNT_W-1:0] used_q, used_d;
  logic [RCNT_W-1:0] rs_count_q, rs_count_d;
  logic [15:0]       prev_time_q, prev_cat_q;
  logic              have_prev_q;
  logic [TCNT_W-1:0] tscan_q;
  logic              tpend_q;
  logic [RCNT_W-1:0] rscan_q;
  logic              rpend_q;
  logic              r_found_q;
  logic [TIDX_W-1:0] ent_idx_q, ent_idx_d;
  logic              is_new_q;
  logic [15:0]       key_rd_q, epi_rd_q, rs_rd_q;
  logic [31:0]       cyc_rd_q;
  logic              out_valid_q, out_valid_d;
  pca_out_t          out_q, out_d;

  logic                t_hit, t_end, t_issue, t_full;
  logic                r_hit, r_end, r_issue, rs_full;
  logic                set_full, mark_ins, req_ok, upd, rs_ins;
  logic [TCNT_W-1:0]   tlast;
  logic [TIDX_W-1:0]   key_addr;
  logic [IDXCMP_W-1:0] req_ext;
  logic [15:0]         interval;
  logic [31:0]         cyc_new;
  logic [15:0]         epi_new;
  logic [USEDX_W-1:0]  used_ext;
  status_e             upd_status;

  assign t_hit    = tpend_q && (key_rd_q == prev_cat_q);
  assign t_end    = (tscan_q == used_q);
  assign t_issue  = cmd_i.t_scan && !t_hit && !t_end;
  assign t_full   = (used_q == TCNT_W'(TABLE_DEPTH));
  assign r_hit    = rpend_q && (rs_rd_q == prev_cat_q);
  assign r_end    = (rscan_q == rs_count_q);
  assign r_issue  = cmd_i.r_scan && !r_hit && !r_end;
  assign rs_full  = (rs_count_q == RCNT_W'(RUN_SET_DEPTH));
  assign set_full = !r_found_q && rs_full;
  assign mark_ins = !r_found_q && !rs_full;
  assign tlast    = tscan_q - TCNT_W'(1);
  assign req_ext  = IDXCMP_W'(in_q.entry_index);
  assign req_ok   = req_ext < IDXCMP_W'(used_q);
  assign key_addr = t_issue ? tscan_q[TIDX_W-1:0] : ent_idx_q;
  assign upd      = cmd_i.finish && (cmd_i.fin_kind == FIN_UPDATE);
  assign rs_ins   = upd && mark_ins;

  // interval since the previous record, less the timestamp overhead, mod 2^16
  assign interval = in_q.timestamp - prev_time_q - overhead_i;
  assign cyc_new  = is_new_q ? 32'(interval) : cyc_rd_q + 32'(interval);
  assign epi_new  = is_new_q ? (set_full ? 16'd0 : 16'd1) : epi_rd_q + 16'(mark_ins);

  always_comb begin
    if (set_full) begin
      upd_status = ST_SET_FULL;
    end else if (is_new_q) begin
      upd_status = ST_NEW;
    end else begin
      upd_status = ST_ACCUM;
    end
  end

  always_comb begin
    case (cmd_i.ent_sel)
      SEL_HIT: ent_idx_d = tlast[TIDX_W-1:0];
      SEL_NEW: ent_idx_d = used_q[TIDX_W-1:0];
      SEL_REQ: ent_idx_d = req_ext[TIDX_W-1:0];
      default: ent_idx_d = ent_idx_q;
    endcase
  end

  always_comb begin
    used_d = used_q;
    if (upd && is_new_q) begin
      used_d = used_q + TCNT_W'(1);
    end
    rs_count_d = rs_count_q;
    if (cmd_i.finish && (cmd_i.fin_kind == FIN_START)) begin
      rs_count_d = '0;
    end else if (rs_ins) begin
      rs_count_d = rs_count_q + RCNT_W'(1);
    end
  end

  assign used_ext = USEDX_W'(used_d);

  always_comb begin
    out_d                = out_q;
    out_d.entries_used   = used_ext[USED_OUT_W-1:0];
    out_d.entry_cycles   = '0;
    out_d.entry_episodes = '0;
    case (cmd_i.fin_kind)
      FIN_START: begin
        out_d.status         = ST_RUN_START;
        out_d.entry_category = in_q.category;
      end
      FIN_TFULL: begin
        out_d.status         = ST_TABLE_FULL;
        out_d.entry_category = prev_cat_q;
      end
      FIN_UPDATE: begin
        out_d.status         = upd_status;
        out_d.entry_category = prev_cat_q;
        out_d.entry_cycles   = cyc_new;
        out_d.entry_episodes = epi_new;
      end
      FIN_READ: begin
        if (req_ok) begin
          out_d.status         = ST_READ_OK;
          out_d.entry_category = key_rd_q;
          out_d.entry_cycles   = cyc_rd_q;
          out_d.entry_episodes = epi_rd_q;
        end else begin
          out_d.status         = ST_READ_BAD;
          out_d.entry_category = '0;
        end
      end
      default: begin
        out_d.status         = ST_READ_BAD;
        out_d.entry_category = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // table memories: one read port and one write port each
  always_ff @(posedge clk_i) begin
    if (upd) begin
      key_mem[ent_idx_q] <= prev_cat_q;
    end
    if (t_issue || cmd_i.rd_entry) begin
      key_rd_q <= key_mem[key_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      cyc_mem[ent_idx_q] <= cyc_new;
    end
    if (cmd_i.rd_entry) begin
      cyc_rd_q <= cyc_mem[ent_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      epi_mem[ent_idx_q] <= epi_new;
    end
    if (cmd_i.rd_entry) begin
      epi_rd_q <= epi_mem[ent_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rs_ins) begin
      rs_mem[rs_count_q[RIDX_W-1:0]] <= prev_cat_q;
    end
    if (r_issue) begin
      rs_rd_q <= rs_mem[rscan_q[RIDX_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.ent_latch) begin
      ent_idx_q <= ent_idx_d;
      is_new_q  <= (cmd_i.ent_sel == SEL_NEW);
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      rs_count_q  <= '0;
      prev_time_q <= '0;
      prev_cat_q  <= '0;
      have_prev_q <= 1'b0;
      tscan_q     <= '0;
      tpend_q     <= 1'b0;
      rscan_q     <= '0;
      rpend_q     <= 1'b0;
      r_found_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      rs_count_q  <= rs_count_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.finish && (cmd_i.fin_kind != FIN_READ)) begin
        prev_time_q <= in_q.timestamp;
        prev_cat_q  <= in_q.category;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.t_start) begin
        tscan_q   <= '0;
        tpend_q   <= 1'b0;
        rscan_q   <= '0;
        rpend_q   <= 1'b0;
        r_found_q <= 1'b0;
      end else begin
        if (cmd_i.t_scan) begin
          tpend_q <= t_issue;
          if (t_issue) begin
            tscan_q <= tscan_q + TCNT_W'(1);
          end
        end
        if (cmd_i.r_scan) begin
          rpend_q <= r_issue;
          if (r_issue) begin
            rscan_q <= rscan_q + RCNT_W'(1);
          end
          if (r_hit) begin
            r_found_q <= 1'b1;
          end
        end
      end
    end
  end

  assign stat_o.cmd_read  = in_q.command;
  assign stat_o.cmd_first = in_q.first_in_run;
  assign stat_o.have_prev = have_prev_q;
  assign stat_o.req_ok    = req_ok;
  assign stat_o.t_hit     = t_hit;
  assign stat_o.t_end     = t_end;
  assign stat_o.t_full    = t_full;
  assign stat_o.r_hit     = r_hit;
  assign stat_o.r_end     = r_end;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_read_no_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && (cmd_i.fin_kind == FIN_READ)
    |=> $stable(used_q) && $stable(rs_count_q) && $stable(prev_cat_q))
    else $error("read item changed table state");

  a_start_clears_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && (cmd_i.fin_kind == FIN_START) |=> (rs_count_q == '0) && have_prev_q)
    else $error("run start did not clear the run set");

  a_new_entry_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && is_new_q |=> used_q == $past(used_q) + TCNT_W'(1))
    else $error("new entry did not bump the fill count");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result appeared without a finished item");

endmodule
